@@ sv/bodr_pkg.sv @@
// ----------------------------------------------------------------------------
// bodr_pkg
// Types, register indexes and leg tables of the open-loop drag ramp.
// ----------------------------------------------------------------------------
package bodr_pkg;

  localparam int unsigned REG_W   = 16;
  localparam int unsigned DUTY_W  = 16;
  localparam int unsigned IDX_W   = 3;

  // configuration register indexes
  localparam logic [IDX_W-1:0] REG_PERIOD_START   = 3'd0;
  localparam logic [IDX_W-1:0] REG_PERIOD_DIVISOR = 3'd1;
  localparam logic [IDX_W-1:0] REG_PERIOD_END     = 3'd2;
  localparam logic [IDX_W-1:0] REG_DUTY_INCREMENT = 3'd3;
  localparam logic [IDX_W-1:0] REG_DUTY_MINIMUM   = 3'd4;
  localparam logic [IDX_W-1:0] REG_DUTY_MAXIMUM   = 3'd5;
  localparam logic [IDX_W-1:0] REG_ALIGN_DUTY     = 3'd6;

  // register reset values
  localparam logic [REG_W-1:0] RST_PERIOD_START   = 16'd190;
  localparam logic [REG_W-1:0] RST_PERIOD_DIVISOR = 16'd9;
  localparam logic [REG_W-1:0] RST_PERIOD_END     = 16'd20;
  localparam logic [REG_W-1:0] RST_DUTY_INCREMENT = 16'd10;
  localparam logic [REG_W-1:0] RST_DUTY_MINIMUM   = 16'd100;
  localparam logic [REG_W-1:0] RST_DUTY_MAXIMUM   = 16'd300;
  localparam logic [REG_W-1:0] RST_ALIGN_DUTY     = 16'd100;

  localparam logic [2:0] STEP_FIRST = 3'd1;
  localparam logic [2:0] STEP_LAST  = 3'd6;

  typedef enum logic [1:0] {
    RS_IDLE = 2'd0,
    RS_DRAG = 2'd1,
    RS_RUN  = 2'd2
  } run_state_e;

  typedef enum logic [2:0] {
    SQ_IDLE,
    SQ_TICK,
    SQ_DIV,
    SQ_UPD,
    SQ_END,
    SQ_CLAMP,
    SQ_PUT
  } seq_state_e;

  typedef enum logic [1:0] {
    LEG_A = 2'd0,
    LEG_B = 2'd1,
    LEG_C = 2'd2
  } leg_e;

  typedef struct packed {
    logic       mode;
    logic [2:0] start_phase;
  } in_item_t;

  typedef struct packed {
    logic [1:0]        run_state;
    logic [DUTY_W-1:0] duty;
    logic [2:0]        phase;
    logic [1:0]        high_leg;
    logic [1:0]        low_leg;
    logic              commutated;
    logic              entered_run;
    logic [15:0]       period_now;
  } out_item_t;

  // fold a step code into 1..6
  function automatic logic [2:0] wrap_step(input logic [2:0] s);
    logic [2:0] r;
    r = s;
    if (s > STEP_LAST) begin
      r = STEP_FIRST;
    end else if (s < STEP_FIRST) begin
      r = STEP_LAST;
    end
    return r;
  endfunction

  function automatic leg_e high_leg_of(input logic [2:0] s);
    leg_e r;
    unique case (s)
      3'd3, 3'd4: r = LEG_B;
      3'd5, 3'd6: r = LEG_C;
      default:    r = LEG_A;
    endcase
    return r;
  endfunction

  function automatic leg_e low_leg_of(input logic [2:0] s);
    leg_e r;
    unique case (s)
      3'd1, 3'd6: r = LEG_B;
      3'd2, 3'd3: r = LEG_C;
      default:    r = LEG_A;
    endcase
    return r;
  endfunction

endpackage

@@ sv/bodr_stream_if.sv @@
// ----------------------------------------------------------------------------
// bodr_stream_if
// Valid/ready channel carrying one payload item per handshake.
// ----------------------------------------------------------------------------
interface bodr_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

@@ sv/bldc_open_loop_drag_ramp_core.sv @@
// ----------------------------------------------------------------------------
// bldc_open_loop_drag_ramp_core
// Open-loop startup ramp of a six-step sensorless drive: start and tick
// items in, one status item out per item.
// ----------------------------------------------------------------------------
//  channel  dir  payload                                   handshake
//  in_i     in   mode, start_phase                         valid/ready
//  out_o    out  run_state, duty, phase, legs, flags, per  valid/ready
//  cfg      in   cfg_idx_i, cfg_data_i                     cfg_we_i only
//
//  start item or tick outside drag: idle, put; drag tick below the period:
//  idle, tick, clamp, put; drag tick that reaches the period: idle, tick,
//  div, upd, end, clamp, put, without clamp when it ends the ramp; the
//  restoring divider in div takes one quotient bit per cycle.
//  in_i.ready is high only while the sequencer is idle; a finished item
//  waits in the sequencer until the output register is free, so one
//  result may sit in out_o while the next item is worked on.
//  reset restores register defaults, idle mode, step one, empty output.
// ----------------------------------------------------------------------------
module bldc_open_loop_drag_ramp_core #(
  parameter int unsigned TIME_WIDTH = 16
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    cfg_we_i,
  input  logic [bodr_pkg::IDX_W-1:0] cfg_idx_i,
  input  logic [bodr_pkg::REG_W-1:0] cfg_data_i,
  bodr_stream_if.sink             in_i,
  bodr_stream_if.source           out_o
);
  import bodr_pkg::*;

  localparam int unsigned TW = TIME_WIDTH;
  localparam int unsigned CW = $clog2(TIME_WIDTH + 1);

  // configuration registers
  logic [REG_W-1:0] period_start_q, period_divisor_q, period_end_q;
  logic [REG_W-1:0] duty_increment_q, duty_minimum_q, duty_maximum_q;
  logic [REG_W-1:0] align_duty_q;

  // ramp state
  run_state_e        run_mode_q;
  logic [TW-1:0]     tick_q;
  logic [TW-1:0]     period_q;
  logic [DUTY_W-1:0] duty_q;
  logic [2:0]        step_q;
  logic              comm_q, ended_q;

  // divider
  logic [REG_W-1:0]  rem_q;
  logic [TW-1:0]     quo_q;
  logic [CW-1:0]     cnt_q;
  logic [REG_W-1:0]  divisor;
  logic [REG_W:0]    trial;
  logic              trial_ge;

  // update path
  logic [TW:0]       dec;
  logic [TW-1:0]     period_shrunk;
  logic [DUTY_W:0]   duty_sum;
  logic [TW-1:0]     end_t;

  logic              out_valid_q;
  out_item_t         out_data_q;

  seq_state_e        seq_q, seq_d;
  logic              in_fire, put_fire;

  assign in_fire  = in_i.valid && in_i.ready;
  assign put_fire = (seq_q == SQ_PUT) && (!out_valid_q || out_o.ready);

  assign divisor  = (period_divisor_q == '0) ? REG_W'(1) : period_divisor_q;
  assign trial    = {rem_q, quo_q[TW-1]};
  assign trial_ge = trial >= {1'b0, divisor};

  assign dec           = {1'b0, quo_q} + (TW+1)'(1);
  assign period_shrunk = ({1'b0, period_q} > dec) ? (period_q - dec[TW-1:0]) : '0;
  assign duty_sum      = {1'b0, duty_q} + {1'b0, duty_increment_q};
  assign end_t         = TW'(period_end_q);

  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seq_q <= SQ_IDLE;
    end else begin
      seq_q <= seq_d;
    end
  end

  always_comb begin
    seq_d      = seq_q;
    in_i.ready = 1'b0;
    unique case (seq_q)
      SQ_IDLE: begin
        in_i.ready = 1'b1;
        if (in_i.valid) begin
          if (!in_i.data.mode && (run_mode_q == RS_DRAG)) begin
            seq_d = SQ_TICK;
          end else begin
            seq_d = SQ_PUT;
          end
        end
      end
      SQ_TICK:  seq_d = (tick_q >= period_q) ? SQ_DIV : SQ_CLAMP;
      SQ_DIV:   seq_d = (cnt_q == CW'(1)) ? SQ_UPD : SQ_DIV;
      SQ_UPD:   seq_d = SQ_END;
      SQ_END:   seq_d = (period_q < end_t) ? SQ_PUT : SQ_CLAMP;
      SQ_CLAMP: seq_d = SQ_PUT;
      SQ_PUT:   seq_d = put_fire ? SQ_IDLE : SQ_PUT;
      default:  seq_d = SQ_IDLE;
    endcase
  end

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      period_start_q   <= RST_PERIOD_START;
      period_divisor_q <= RST_PERIOD_DIVISOR;
      period_end_q     <= RST_PERIOD_END;
      duty_increment_q <= RST_DUTY_INCREMENT;
      duty_minimum_q   <= RST_DUTY_MINIMUM;
      duty_maximum_q   <= RST_DUTY_MAXIMUM;
      align_duty_q     <= RST_ALIGN_DUTY;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_PERIOD_START:   period_start_q   <= cfg_data_i;
        REG_PERIOD_DIVISOR: period_divisor_q <= cfg_data_i;
        REG_PERIOD_END:     period_end_q     <= cfg_data_i;
        REG_DUTY_INCREMENT: duty_increment_q <= cfg_data_i;
        REG_DUTY_MINIMUM:   duty_minimum_q   <= cfg_data_i;
        REG_DUTY_MAXIMUM:   duty_maximum_q   <= cfg_data_i;
        REG_ALIGN_DUTY:     align_duty_q     <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // ramp state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_mode_q <= RS_IDLE;
      tick_q     <= '0;
      period_q   <= '0;
      duty_q     <= '0;
      step_q     <= STEP_FIRST;
      comm_q     <= 1'b0;
      ended_q    <= 1'b0;
    end else begin
      unique case (seq_q)
        SQ_IDLE: begin
          if (in_fire) begin
            comm_q  <= 1'b0;
            ended_q <= 1'b0;
            if (in_i.data.mode) begin
              duty_q     <= align_duty_q;
              tick_q     <= '0;
              period_q   <= TW'(period_start_q);
              run_mode_q <= RS_DRAG;
              step_q     <= wrap_step(in_i.data.start_phase);
            end else if (run_mode_q == RS_DRAG) begin
              tick_q <= tick_q + TW'(1);
            end
          end
        end
        SQ_UPD: begin
          tick_q   <= '0;
          duty_q   <= duty_sum[DUTY_W] ? '1 : duty_sum[DUTY_W-1:0];
          period_q <= period_shrunk;
        end
        SQ_END: begin
          if (period_q < end_t) begin
            period_q   <= end_t;
            run_mode_q <= RS_RUN;
            ended_q    <= 1'b1;
          end else begin
            step_q <= (step_q >= STEP_LAST) ? STEP_FIRST : step_q + 3'd1;
            comm_q <= 1'b1;
          end
        end
        SQ_CLAMP: begin
          // minimum is checked first, so a duty below it gets the minimum even when the maximum is lower
          if (duty_q < duty_minimum_q) begin
            duty_q <= duty_minimum_q;
          end else if (duty_q > duty_maximum_q) begin
            duty_q <= duty_maximum_q;
          end
        end
        default: ;
      endcase
    end
  end

  // restoring divider, one quotient bit per cycle
  always_ff @(posedge clk_i) begin
    if ((seq_q == SQ_TICK) && (tick_q >= period_q)) begin
      rem_q <= '0;
      quo_q <= period_q;
      cnt_q <= CW'(TW);
    end else if (seq_q == SQ_DIV) begin
      rem_q <= trial_ge ? REG_W'(trial - {1'b0, divisor}) : trial[REG_W-1:0];
      if (TW > 1) begin
        quo_q <= {quo_q[TW-2:0], trial_ge};
      end else begin
        quo_q <= TW'(trial_ge);
      end
      cnt_q <= cnt_q - CW'(1);
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (put_fire) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (put_fire) begin
      out_data_q.run_state   <= run_mode_q;
      out_data_q.duty        <= duty_q;
      out_data_q.phase       <= step_q;
      out_data_q.high_leg    <= high_leg_of(step_q);
      out_data_q.low_leg     <= low_leg_of(step_q);
      out_data_q.commutated  <= comm_q;
      out_data_q.entered_run <= ended_q;
      out_data_q.period_now  <= 16'(period_q);
    end
  end

endmodule
